// ===== rtl/core/cbro_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis package
// Shared constants, command codes, the accumulator control type and the
// arithmetic helpers of the camera basis block.
// ----------------------------------------------------------------------------
package cbro_pkg;

	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_ITERS = 16;
	localparam int AXIS_W       = 16;
	localparam int POS_W        = 32;
	localparam int MAC_W        = 33;
	localparam int ACC_W        = 64;
	localparam int CORD_W       = 34;
	localparam int NRM_PRE      = 14;
	localparam int DIV_QB       = 17;
	localparam int DIV_NW       = MAC_W + FRAC_BITS + 1;
	localparam int DIV_CW       = (DIV_NW + 1 > MAC_W + DIV_QB) ? DIV_NW + 1 : MAC_W + DIV_QB;
	localparam int REG_COUNT    = 3;

	localparam logic signed [AXIS_W-1:0] AXIS_ONE =
		(FRAC_BITS >= 15) ? 16'sd32767 : AXIS_W'(1 << FRAC_BITS);
	localparam logic signed [CORD_W-1:0] CORDIC_K      = 34'sd652032874;
	localparam logic signed [CORD_W-1:0] DEG64_TO_Q30  = 34'sd292818;
	localparam logic signed [16:0]       FULL_TURN     = 17'sd23040;
	localparam logic signed [16:0]       HALF_TURN     = 17'sd11520;
	localparam logic signed [16:0]       QUARTER_TURN  = 17'sd5760;

	typedef enum logic [2:0] {
		CMD_LD_FWD = 3'd0,
		CMD_LD_RGT = 3'd1,
		CMD_LD_UP  = 3'd2,
		CMD_ROTATE = 3'd3,
		CMD_ORTHO  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic neg;
	} mac_ctl_t;

	function automatic logic signed [CORD_W-1:0] atan_q30(input logic [5:0] i);
		logic signed [CORD_W-1:0] r;
		r = '0;
		if (i < 6'd10) begin
			unique case (i)
				6'd0: r = 34'sd843314857;
				6'd1: r = 34'sd497837830;
				6'd2: r = 34'sd263043837;
				6'd3: r = 34'sd133525159;
				6'd4: r = 34'sd67021687;
				6'd5: r = 34'sd33543516;
				6'd6: r = 34'sd16775851;
				6'd7: r = 34'sd8388437;
				6'd8: r = 34'sd4194283;
				default: r = 34'sd2097149;
			endcase
		end else if (i <= 6'd30) begin
			r = CORD_W'(1) <<< (6'd30 - i);
		end
		return r;
	endfunction

	function automatic logic signed [AXIS_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [AXIS_W-1:0] r;
		if (v > 64'sd32767) begin
			r = 16'sd32767;
		end else if (v < -64'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[AXIS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/cbro_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed multiplier feeding a 64-bit wrapping accumulator that can be
// cleared, and the product negated, on each enabled cycle.
// ----------------------------------------------------------------------------
module cbro_mac import cbro_pkg::*; (
	input  logic                    clk,
	input  mac_ctl_t                ctl,
	input  logic signed [MAC_W-1:0] op_a,
	input  logic signed [MAC_W-1:0] op_b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*MAC_W-1:0] prod;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   acc_q;

	assign prod = op_a * op_b;
	assign term = ctl.neg ? -prod[ACC_W-1:0] : prod[ACC_W-1:0];
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? '0 : acc_q) + term;
		end
	end

endmodule

// ===== rtl/core/camera_basis_rotate_orthonormalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis rotate and orthonormalize
// Holds the forward, right and up axes of a camera, applies load, rotate and
// orthonormalize commands and reports the axes with the view translation.
// ----------------------------------------------------------------------------
// The input stream carries one command per transfer: tuser holds the command,
// tdata the load vector and the roll, pitch and yaw angles. Each accepted
// command gives exactly one output transfer with the nine axis components and
// the three view translation terms. The position registers are written through
// the cfg port; the user must write them only while the block is idle, which
// the block does not enforce. One command is processed at a time; s_axis_tready
// is high only when the sequencer is idle. All arithmetic runs through one
// shared multiply-accumulate unit plus a CORDIC, a square-root and a divider
// step. A rotate runs the CORDIC for each of the three angles, then turns each
// axis by three plane rotations of product pairs; an orthonormalize runs two
// normalizations of 32 square-root steps and three 17-step divisions each, with
// a cross product after each normalization. The view translation then ends
// every command. The next command is taken after the output register is loaded.
// Reset returns the axes to the identity basis and the position to zero.
// When the receiver stalls, the finished result waits in the output register;
// the block may take one further command but holds that result back until the
// waiting one has been taken.
// ----------------------------------------------------------------------------
module camera_basis_rotate_orthonormalize import cbro_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vec_x, vec_y, vec_z, pitch_deg, yaw_deg, roll_deg
	input  logic [95:0]  s_axis_tdata,
	// cmd
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// forward_x/y/z, right_x/y/z, up_x/y/z, view_tx, view_ty, view_tz
	output logic [239:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_ANG, S_COR, S_RLD, S_ROT, S_NSUM, S_NSQI, S_NSQ,
		S_NDP, S_NDI, S_NDF, S_XP, S_VIEW, S_OUT
	} state_t;

	state_t                   state_q;
	logic signed [AXIS_W-1:0] ax_q [9];
	logic signed [POS_W-1:0]  pos_q [3];
	logic signed [AXIS_W-1:0] ang_q [3];
	logic signed [MAC_W-1:0]  cs_q [6];
	logic signed [CORD_W-1:0] cx_q, cy_q, cz_q;
	logic                     flip_q;
	logic signed [AXIS_W-1:0] w_q [3];
	logic signed [AXIS_W-1:0] res_q;
	logic signed [AXIS_W-1:0] fn_q [3];
	logic signed [AXIS_W-1:0] nrm_q [3];
	logic signed [MAC_W-1:0]  vc_q [3];
	logic [ACC_W-1:0]         sq_v_q, sq_r_q, sq_bit_q;
	logic                     zero_q;
	logic [DIV_NW-1:0]        rem_q;
	logic [DIV_QB-1:0]        quo_q;
	logic                     dsat_q;
	logic signed [POS_W-1:0]  vt_q [3];
	logic [1:0]               k_q, st_q, vb_q, t_q;
	logic                     o_q, nsel_q, xsel_q;
	logic [5:0]               it_q;
	logic                     out_valid_q;
	logic [239:0]             out_data_q;

	mac_ctl_t                 mac_ctl;
	logic signed [MAC_W-1:0]  mac_a, mac_b;
	logic signed [ACC_W-1:0]  acc;

	cbro_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (mac_a),
		.op_b (mac_b),
		.acc  (acc)
	);

	// Vector base in the axis store: forward at 0, right at 3, up at 6.
	logic [3:0] rb0, rb1, rb2, vbase;
	assign rb0 = {1'b0, vb_q, 1'b0} + {2'b00, vb_q};
	assign rb1 = rb0 + 4'd1;
	assign rb2 = rb0 + 4'd2;
	always_comb begin
		unique case (vb_q)
			2'd0:    vbase = 4'd3;
			2'd1:    vbase = 4'd6;
			default: vbase = 4'd0;
		endcase
	end

	// Angle reduction and fold for the CORDIC start value.
	logic signed [16:0]       ang_ext, ang_m, ang_h, ang_f;
	logic                     ang_flip;
	logic signed [CORD_W-1:0] z_init;
	always_comb begin
		ang_ext = 17'(ang_q[k_q]);
		if (ang_ext >= FULL_TURN) begin
			ang_m = ang_ext - FULL_TURN;
		end else if (ang_ext <= -FULL_TURN) begin
			ang_m = ang_ext + FULL_TURN;
		end else begin
			ang_m = ang_ext;
		end
		if (ang_m >= HALF_TURN) begin
			ang_h = ang_m - FULL_TURN;
		end else if (ang_m < -HALF_TURN) begin
			ang_h = ang_m + FULL_TURN;
		end else begin
			ang_h = ang_m;
		end
		ang_flip = 1'b0;
		if (ang_h > QUARTER_TURN) begin
			ang_f    = ang_h - HALF_TURN;
			ang_flip = 1'b1;
		end else if (ang_h < -QUARTER_TURN) begin
			ang_f    = ang_h + HALF_TURN;
			ang_flip = 1'b1;
		end else begin
			ang_f = ang_h;
		end
		z_init = CORD_W'(ang_f) * DEG64_TO_Q30;
	end

	// One CORDIC rotation step.
	logic signed [CORD_W-1:0] xs, ys, at, nx, ny, nz;
	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		at = atan_q30(it_q);
		if (!cz_q[CORD_W-1]) begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - at;
		end else begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + at;
		end
	end

	// Operand routing for the rotation terms.
	logic [1:0] rc_idx;
	logic [2:0] rk_idx;
	logic       r_neg;
	always_comb begin
		unique case ({st_q, o_q, t_q[0]})
			4'b0000: begin rc_idx = 2'd0; rk_idx = 3'd0; r_neg = 1'b0; end
			4'b0001: begin rc_idx = 2'd1; rk_idx = 3'd1; r_neg = 1'b1; end
			4'b0010: begin rc_idx = 2'd0; rk_idx = 3'd1; r_neg = 1'b0; end
			4'b0011: begin rc_idx = 2'd1; rk_idx = 3'd0; r_neg = 1'b0; end
			4'b0100: begin rc_idx = 2'd1; rk_idx = 3'd2; r_neg = 1'b0; end
			4'b0101: begin rc_idx = 2'd2; rk_idx = 3'd3; r_neg = 1'b1; end
			4'b0110: begin rc_idx = 2'd1; rk_idx = 3'd3; r_neg = 1'b0; end
			4'b0111: begin rc_idx = 2'd2; rk_idx = 3'd2; r_neg = 1'b0; end
			4'b1000: begin rc_idx = 2'd0; rk_idx = 3'd4; r_neg = 1'b0; end
			4'b1001: begin rc_idx = 2'd2; rk_idx = 3'd5; r_neg = 1'b0; end
			4'b1010: begin rc_idx = 2'd2; rk_idx = 3'd4; r_neg = 1'b0; end
			4'b1011: begin rc_idx = 2'd0; rk_idx = 3'd5; r_neg = 1'b1; end
			default: begin rc_idx = 2'd0; rk_idx = 3'd0; r_neg = 1'b0; end
		endcase
	end

	// Cross product component pairs.
	logic [1:0]               xi, xj;
	logic signed [AXIS_W-1:0] xa_i, xa_j, xb_i, xb_j;
	always_comb begin
		unique case (k_q)
			2'd0:    begin xi = 2'd1; xj = 2'd2; end
			2'd1:    begin xi = 2'd2; xj = 2'd0; end
			default: begin xi = 2'd0; xj = 2'd1; end
		endcase
		if (xsel_q) begin
			xa_i = nrm_q[xi];
			xa_j = nrm_q[xj];
			xb_i = fn_q[xi];
			xb_j = fn_q[xj];
		end else begin
			xa_i = fn_q[xi];
			xa_j = fn_q[xj];
			xb_i = ax_q[4'd3 + {2'b00, xi}];
			xb_j = ax_q[4'd3 + {2'b00, xj}];
		end
	end

	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			S_ROT: begin
				mac_ctl.en  = (t_q != 2'd2);
				mac_ctl.clr = (t_q == 2'd0);
				mac_ctl.neg = r_neg;
				mac_a       = MAC_W'(w_q[rc_idx]);
				mac_b       = cs_q[rk_idx];
			end
			S_NSUM: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.clr = (k_q == 2'd0);
				mac_a       = vc_q[k_q];
				mac_b       = vc_q[k_q];
			end
			S_XP: begin
				mac_ctl.en  = (t_q != 2'd2);
				mac_ctl.clr = (t_q == 2'd0);
				mac_ctl.neg = (t_q == 2'd1);
				mac_a       = MAC_W'((t_q == 2'd0) ? xa_i : xa_j);
				mac_b       = MAC_W'((t_q == 2'd0) ? xb_j : xb_i);
			end
			S_VIEW: begin
				mac_ctl.en  = (t_q != 2'd3);
				mac_ctl.clr = (t_q == 2'd0);
				mac_a       = MAC_W'(pos_q[t_q]);
				mac_b       = MAC_W'(ax_q[vbase + {2'b00, t_q}]);
			end
			default: ;
		endcase
	end

	// Rounded results taken from the accumulator.
	logic signed [AXIS_W-1:0] rot_v, rgt_v;
	logic signed [ACC_W-1:0]  rot_r, rgt_r, view_r, acc_n;
	logic signed [POS_W-1:0]  view_v;
	always_comb begin
		rot_r  = (acc + (64'sd1 <<< 29)) >>> 30;
		rot_v  = sat16(rot_r);
		rgt_r  = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		rgt_v  = sat16(rgt_r);
		acc_n  = -acc;
		view_r = (acc_n + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (view_r > 64'sd2147483647) begin
			view_v = 32'sh7fffffff;
		end else if (view_r < -64'sd2147483648) begin
			view_v = 32'sh80000000;
		end else begin
			view_v = view_r[POS_W-1:0];
		end
	end

	// Square-root step.
	logic [ACC_W-1:0] sq_try;
	logic             sq_ge;
	assign sq_try = sq_r_q + sq_bit_q;
	assign sq_ge  = (sq_v_q >= sq_try);

	// Division set-up and step.
	logic [MAC_W-1:0]  n_root, mag;
	logic [DIV_NW-1:0] num;
	logic [DIV_CW-1:0] dsub;
	logic              d_ge, c_neg;
	assign n_root = sq_r_q[MAC_W-1:0];
	assign c_neg  = vc_q[k_q][MAC_W-1];
	assign mag    = c_neg ? MAC_W'(-vc_q[k_q]) : MAC_W'(vc_q[k_q]);
	assign num    = (DIV_NW'(mag) << FRAC_BITS) + DIV_NW'(n_root >> 1);
	assign dsub   = DIV_CW'(n_root) << it_q;
	assign d_ge   = (DIV_CW'(rem_q) >= dsub);

	logic signed [AXIS_W-1:0] nval;
	logic signed [DIV_QB:0]   quo_s;
	always_comb begin
		quo_s = {1'b0, quo_q};
		if (zero_q) begin
			nval = '0;
		end else if (dsat_q) begin
			nval = c_neg ? -16'sd32768 : 16'sd32767;
		end else if (c_neg) begin
			nval = (quo_q > DIV_QB'(32768)) ? -16'sd32768 : AXIS_W'(-quo_s);
		end else begin
			nval = (quo_q > DIV_QB'(32767)) ? 16'sd32767 : AXIS_W'(quo_s);
		end
	end

	logic [15:0] vx, vy, vz;
	assign vx = s_axis_tdata[15:0];
	assign vy = s_axis_tdata[31:16];
	assign vz = s_axis_tdata[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				ax_q[i] <= (i == 2 || i == 3 || i == 7) ? AXIS_ONE : '0;
			end
			for (int i = 0; i < REG_COUNT; i++) begin
				pos_q[i] <= '0;
			end
			k_q         <= '0;
			st_q        <= '0;
			vb_q        <= '0;
			t_q         <= '0;
			o_q         <= 1'b0;
			nsel_q      <= 1'b0;
			xsel_q      <= 1'b0;
			it_q        <= '0;
		end else begin
			if (cfg_we && (cfg_idx < 2'(REG_COUNT))) begin
				pos_q[cfg_idx] <= cfg_data;
			end
			if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						ang_q[0] <= s_axis_tdata[95:80];
						ang_q[1] <= s_axis_tdata[63:48];
						ang_q[2] <= s_axis_tdata[79:64];
						k_q      <= '0;
						vb_q     <= '0;
						t_q      <= '0;
						nsel_q   <= 1'b0;
						state_q  <= S_VIEW;
						unique case (s_axis_tuser)
							CMD_LD_FWD: begin
								ax_q[0] <= vx; ax_q[1] <= vy; ax_q[2] <= vz;
							end
							CMD_LD_RGT: begin
								ax_q[3] <= vx; ax_q[4] <= vy; ax_q[5] <= vz;
							end
							CMD_LD_UP: begin
								ax_q[6] <= vx; ax_q[7] <= vy; ax_q[8] <= vz;
							end
							CMD_ROTATE: begin
								state_q <= S_ANG;
							end
							CMD_ORTHO: begin
								for (int i = 0; i < 3; i++) begin
									vc_q[i] <= MAC_W'(ax_q[i]) <<< NRM_PRE;
								end
								state_q <= S_NSUM;
							end
							default: ;
						endcase
					end
				end
				S_ANG: begin
					cx_q    <= CORDIC_K;
					cy_q    <= '0;
					cz_q    <= z_init;
					flip_q  <= ang_flip;
					it_q    <= '0;
					state_q <= S_COR;
				end
				S_COR: begin
					cx_q <= nx;
					cy_q <= ny;
					cz_q <= nz;
					it_q <= it_q + 6'd1;
					if (it_q == 6'(CORDIC_ITERS - 1)) begin
						cs_q[{k_q, 1'b0}] <= MAC_W'(flip_q ? -nx : nx);
						cs_q[{k_q, 1'b1}] <= MAC_W'(flip_q ? -ny : ny);
						if (k_q == 2'd2) begin
							vb_q    <= '0;
							state_q <= S_RLD;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_ANG;
						end
					end
				end
				S_RLD: begin
					w_q[0]  <= ax_q[rb0];
					w_q[1]  <= ax_q[rb1];
					w_q[2]  <= ax_q[rb2];
					st_q    <= '0;
					o_q     <= 1'b0;
					t_q     <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (t_q == 2'd2) begin
						t_q <= '0;
						if (!o_q) begin
							res_q <= rot_v;
							o_q   <= 1'b1;
						end else begin
							o_q <= 1'b0;
							unique case (st_q)
								2'd0: begin
									w_q[0] <= res_q;
									w_q[1] <= rot_v;
								end
								2'd1: begin
									w_q[1] <= res_q;
									w_q[2] <= rot_v;
								end
								default: begin
									ax_q[rb0] <= res_q;
									ax_q[rb1] <= w_q[1];
									ax_q[rb2] <= rot_v;
								end
							endcase
							if (st_q == 2'd2) begin
								st_q <= '0;
								if (vb_q == 2'd2) begin
									vb_q    <= '0;
									state_q <= S_VIEW;
								end else begin
									vb_q    <= vb_q + 2'd1;
									state_q <= S_RLD;
								end
							end else begin
								st_q <= st_q + 2'd1;
							end
						end
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_NSUM: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_NSQI;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NSQI: begin
					sq_v_q   <= acc;
					sq_r_q   <= '0;
					sq_bit_q <= ACC_W'(1) << (ACC_W - 2);
					zero_q   <= (acc == '0);
					it_q     <= '0;
					state_q  <= S_NSQ;
				end
				S_NSQ: begin
					if (sq_ge) begin
						sq_v_q <= sq_v_q - sq_try;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					it_q     <= it_q + 6'd1;
					if (it_q == 6'(ACC_W / 2 - 1)) begin
						k_q     <= '0;
						state_q <= S_NDP;
					end
				end
				S_NDP: begin
					rem_q   <= num;
					quo_q   <= '0;
					dsat_q  <= (DIV_CW'(num) >= (DIV_CW'(n_root) << DIV_QB));
					it_q    <= 6'(DIV_QB - 1);
					state_q <= S_NDI;
				end
				S_NDI: begin
					if (d_ge) begin
						rem_q <= DIV_NW'(DIV_CW'(rem_q) - dsub);
					end
					quo_q <= {quo_q[DIV_QB-2:0], d_ge};
					if (it_q == 6'd0) begin
						state_q <= S_NDF;
					end else begin
						it_q <= it_q - 6'd1;
					end
				end
				S_NDF: begin
					nrm_q[k_q] <= nval;
					if (k_q == 2'd2) begin
						k_q <= '0;
						t_q <= '0;
						if (!nsel_q) begin
							fn_q[0] <= nrm_q[0];
							fn_q[1] <= nrm_q[1];
							fn_q[2] <= nval;
							xsel_q  <= 1'b0;
						end else begin
							xsel_q  <= 1'b1;
						end
						state_q <= S_XP;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_NDP;
					end
				end
				S_XP: begin
					if (t_q == 2'd2) begin
						t_q <= '0;
						if (!xsel_q) begin
							vc_q[k_q] <= acc[MAC_W-1:0];
						end else begin
							ax_q[4'd3 + {2'b00, k_q}] <= rgt_v;
						end
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (!xsel_q) begin
								nsel_q  <= 1'b1;
								state_q <= S_NSUM;
							end else begin
								for (int i = 0; i < 3; i++) begin
									ax_q[i]     <= fn_q[i];
									ax_q[6 + i] <= nrm_q[i];
								end
								vb_q    <= '0;
								state_q <= S_VIEW;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_VIEW: begin
					if (t_q == 2'd3) begin
						vt_q[vb_q] <= view_v;
						t_q        <= '0;
						if (vb_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							vb_q <= vb_q + 2'd1;
						end
					end else begin
						t_q <= t_q + 2'd1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {vt_q[2], vt_q[1], vt_q[0],
							ax_q[8], ax_q[7], ax_q[6], ax_q[5], ax_q[4], ax_q[3],
							ax_q[2], ax_q[1], ax_q[0]};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/cbro_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis port checker
// Watches the stream ports of the camera basis block over time and is bound
// to the top level.
// ----------------------------------------------------------------------------
module cbro_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [239:0] m_axis_tdata
);

	// A command transfer always occupies the sequencer for the next cycle.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again straight after a transfer");

	// A new result only appears when a command has been in progress.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a command in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transfer changed");

endmodule

bind camera_basis_rotate_orthonormalize cbro_chk u_cbro_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera basis block bench
// Drives load, rotate, orthonormalize and unused commands with random gaps
// and stalls. A local fixed-point copy of the basis predicts every output
// transfer, which is then checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import cbro_pkg::*;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [15:0] vx, vy, vz, pitch, yaw, roll;
	} cam_cmd_t;

	typedef struct packed {
		logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
		logic signed [31:0] tx, ty, tz;
	} basis_out_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [95:0]  s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic [239:0] m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_idx;
	logic [31:0]  cfg_data;

	camera_basis_rotate_orthonormalize u_dut (.*);

	cam_cmd_t   cmd_q[$];
	basis_out_t basis_q[$];
	longint     cam_pos[3];
	logic signed [15:0] fwd[3], rgt[3], upv[3];
	int  fails = 0;
	int  gap_in = 0, gap_out = 0, hold_out = 0;
	bit  quiet = 0;
	bit  in_taken = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	task automatic trig(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys, at;
		bit flip;
		x = 652032874; y = 0; flip = 0;
		ang = ang % 23040;
		if (ang >= 11520) ang -= 23040;
		if (ang < -11520) ang += 23040;
		if (ang > 5760) begin ang -= 11520; flip = 1; end
		else if (ang < -5760) begin ang += 11520; flip = 1; end
		z = ang * 292818;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i; ys = y >>> i;
			case (i)
				0: at = 843314857; 1: at = 497837830; 2: at = 263043837;
				3: at = 133525159; 4: at = 67021687; 5: at = 33543516;
				6: at = 16775851; 7: at = 8388437; 8: at = 4194283;
				9: at = 2097149;
				default: at = (i <= 30) ? (longint'(1) << (30 - i)) : 0;
			endcase
			if (z >= 0) begin x -= ys; y += xs; z -= at; end
			else begin x += ys; y -= xs; z += at; end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic signed [15:0] mix(longint a, longint ka, longint b, longint kb);
		return clip16(rnd_shr(a * ka + b * kb, 30));
	endfunction

	task automatic turn(inout logic signed [15:0] v[3], input longint cs[6]);
		logic signed [15:0] x, y, z, t;
		x = v[0]; y = v[1]; z = v[2];
		t = mix(x, cs[0], y, -cs[1]); y = mix(x, cs[1], y, cs[0]); x = t;
		t = mix(y, cs[2], z, -cs[3]); z = mix(y, cs[3], z, cs[2]); y = t;
		t = mix(x, cs[4], z, cs[5]); z = mix(z, cs[4], x, -cs[5]); x = t;
		v[0] = x; v[1] = y; v[2] = z;
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
			else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	task automatic unit_vec(input longint c[3], output logic signed [15:0] o[3]);
		longint unsigned sum, n, mag, q;
		sum = 0;
		for (int k = 0; k < 3; k++) sum += longint'(c[k] * c[k]);
		if (sum == 0) begin
			o[0] = 0; o[1] = 0; o[2] = 0;
		end else begin
			n = int_sqrt(sum);
			for (int k = 0; k < 3; k++) begin
				mag = (c[k] < 0) ? -c[k] : c[k];
				q = ((mag << FRAC_BITS) + n / 2) / n;
				o[k] = clip16((c[k] < 0) ? -longint'(q) : longint'(q));
			end
		end
	endtask

	task automatic rebuild_basis();
		longint c[3];
		logic signed [15:0] f[3], u[3];
		for (int k = 0; k < 3; k++) c[k] = longint'(fwd[k]) * 16384;
		unit_vec(c, f);
		c[0] = longint'(f[1]) * rgt[2] - longint'(f[2]) * rgt[1];
		c[1] = longint'(f[2]) * rgt[0] - longint'(f[0]) * rgt[2];
		c[2] = longint'(f[0]) * rgt[1] - longint'(f[1]) * rgt[0];
		unit_vec(c, u);
		rgt[0] = clip16(rnd_shr(longint'(u[1]) * f[2] - longint'(u[2]) * f[1], FRAC_BITS));
		rgt[1] = clip16(rnd_shr(longint'(u[2]) * f[0] - longint'(u[0]) * f[2], FRAC_BITS));
		rgt[2] = clip16(rnd_shr(longint'(u[0]) * f[1] - longint'(u[1]) * f[0], FRAC_BITS));
		upv = u; fwd = f;
	endtask

	function automatic logic signed [31:0] view_dot(logic signed [15:0] a[3]);
		longint r;
		r = rnd_shr(-(cam_pos[0] * a[0] + cam_pos[1] * a[1] + cam_pos[2] * a[2]), FRAC_BITS);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return 32'(r);
	endfunction

	task automatic predict_basis(input cam_cmd_t it);
		longint cs[6];
		basis_out_t o;
		case (it.cmd)
			CMD_LD_FWD: begin fwd[0] = it.vx; fwd[1] = it.vy; fwd[2] = it.vz; end
			CMD_LD_RGT: begin rgt[0] = it.vx; rgt[1] = it.vy; rgt[2] = it.vz; end
			CMD_LD_UP:  begin upv[0] = it.vx; upv[1] = it.vy; upv[2] = it.vz; end
			CMD_ROTATE: begin
				trig(it.roll, cs[0], cs[1]);
				trig(it.pitch, cs[2], cs[3]);
				trig(it.yaw, cs[4], cs[5]);
				turn(rgt, cs); turn(upv, cs); turn(fwd, cs);
			end
			CMD_ORTHO: rebuild_basis();
			default: ;
		endcase
		o.fx = fwd[0]; o.fy = fwd[1]; o.fz = fwd[2];
		o.rx = rgt[0]; o.ry = rgt[1]; o.rz = rgt[2];
		o.ux = upv[0]; o.uy = upv[1]; o.uz = upv[2];
		o.tx = view_dot(rgt); o.ty = view_dot(upv); o.tz = view_dot(fwd);
		basis_q.push_back(o);
	endtask

	// Remembers whether the input transfer completed at the last rising edge.
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// Sender: an item leaves the queue only on a completed transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				predict_basis(cmd_q.pop_front());
				gap_in = quiet ? 0 : (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
			end
			if (!s_axis_tvalid || in_taken) begin
				if (gap_in > 0 || cmd_q.size() == 0) begin
					if (gap_in > 0) gap_in--;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= cmd_q[0].cmd;
					s_axis_tdata  <= {cmd_q[0].roll, cmd_q[0].yaw, cmd_q[0].pitch,
						cmd_q[0].vz, cmd_q[0].vy, cmd_q[0].vx};
				end
			end
		end
	end

	// Receiver with random idling and long hold-offs.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_out > 0) begin
				hold_out--;
				m_axis_tready <= 1'b0;
			end else if (gap_out > 0) begin
				gap_out--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) gap_out = $urandom_range(1, 3);
			end
		end
	end

	task automatic chk(string nm, longint e, longint a);
		if (e != a) begin
			$error("%s expected %0d actual %0d", nm, e, a);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		basis_out_t a, e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a = basis_out_t'({m_axis_tdata[47:0], m_axis_tdata[95:48],
				m_axis_tdata[143:96], m_axis_tdata[239:144]});
			// Repack so struct order matches the port order (lowest field first).
			a.fx = m_axis_tdata[15:0];    a.fy = m_axis_tdata[31:16];
			a.fz = m_axis_tdata[47:32];   a.rx = m_axis_tdata[63:48];
			a.ry = m_axis_tdata[79:64];   a.rz = m_axis_tdata[95:80];
			a.ux = m_axis_tdata[111:96];  a.uy = m_axis_tdata[127:112];
			a.uz = m_axis_tdata[143:128]; a.tx = m_axis_tdata[175:144];
			a.ty = m_axis_tdata[207:176]; a.tz = m_axis_tdata[239:208];
			if (basis_q.size() == 0) begin
				$error("output transfer with no expected result");
				fails++;
			end else begin
				e = basis_q.pop_front();
				chk("forward_x", e.fx, a.fx); chk("forward_y", e.fy, a.fy);
				chk("forward_z", e.fz, a.fz); chk("right_x", e.rx, a.rx);
				chk("right_y", e.ry, a.ry);   chk("right_z", e.rz, a.rz);
				chk("up_x", e.ux, a.ux);      chk("up_y", e.uy, a.uy);
				chk("up_z", e.uz, a.uz);      chk("view_tx", e.tx, a.tx);
				chk("view_ty", e.ty, a.ty);   chk("view_tz", e.tz, a.tz);
			end
		end
	end

	function automatic logic signed [15:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 32768)) - 16384);
			3: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cam_cmd_t rnd_cmd();
		cam_cmd_t c;
		c.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		c.vx = rnd_comp(); c.vy = rnd_comp(); c.vz = rnd_comp();
		c.pitch = ($urandom_range(0, 1)) ? 16'($urandom) : 16'(int'($urandom_range(0, 11520)) - 5760);
		c.yaw = 16'($urandom); c.roll = ($urandom_range(0, 1)) ? 16'($urandom) : 16'sd0;
		return c;
	endfunction

	function automatic cam_cmd_t mk(logic [2:0] cm, int x, int y, int z, int p, int yw, int r);
		cam_cmd_t c;
		c.cmd = cm; c.vx = 16'(x); c.vy = 16'(y); c.vz = 16'(z);
		c.pitch = 16'(p); c.yaw = 16'(yw); c.roll = 16'(r);
		return c;
	endfunction

	task automatic drain();
		while (cmd_q.size() != 0 || basis_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_pos(int i, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= 2'(i); cfg_data <= v;
		cam_pos[i] = longint'(signed'(v));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [31:0] pv;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 0;
		cfg_we = 0; cfg_idx = '0; cfg_data = '0;
		cam_pos[0] = 0; cam_pos[1] = 0; cam_pos[2] = 0;
		fwd[0] = 0; fwd[1] = 0; fwd[2] = AXIS_ONE;
		rgt[0] = AXIS_ONE; rgt[1] = 0; rgt[2] = 0;
		upv[0] = 0; upv[1] = AXIS_ONE; upv[2] = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n = 1;

		set_pos(0, 32'h0001_8000); set_pos(1, 32'hFFFE_0000); set_pos(2, 32'h0003_0000);
		// Directed: identity, rotation extremes, zero vector, unused codes.
		cmd_q.push_back(mk(CMD_ROTATE, 0, 0, 0, 5760, 0, 0));
		cmd_q.push_back(mk(CMD_ROTATE, 0, 0, 0, 0, 11520, 0));
		cmd_q.push_back(mk(CMD_ROTATE, 0, 0, 0, 0, 0, -11520));
		cmd_q.push_back(mk(CMD_ROTATE, 0, 0, 0, 32767, -32768, 23040));
		cmd_q.push_back(mk(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_FWD, 32767, 32767, 32767, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_RGT, -32768, -32768, -32768, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_UP, 32767, -32768, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_ROTATE, 0, 0, 0, 1000, 2000, 3000));
		cmd_q.push_back(mk(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_FWD, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_FWD, 100, -200, 16384, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_RGT, 16384, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(3'd5, 1, 2, 3, 4, 5, 6));
		cmd_q.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(3'd7, -1, -1, -1, -1, -1, -1));
		drain();

		// Extreme positions drive the translation into saturation.
		set_pos(0, 32'h7FFF_FFFF); set_pos(1, 32'h7FFF_FFFF); set_pos(2, 32'h8000_0000);
		cmd_q.push_back(mk(CMD_LD_FWD, 32767, 32767, 32767, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_RGT, -32768, -32768, -32768, 0, 0, 0));
		cmd_q.push_back(mk(CMD_LD_UP, 32767, 32767, -32768, 0, 0, 0));
		for (int i = 0; i < 20; i++) cmd_q.push_back(rnd_cmd());
		// The receiver holds off while the sender keeps offering.
		hold_out = 400;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < 3; r++) begin
				pv = $urandom;
				if (ph == 1) pv = 32'h8000_0000;
				if (ph == 2) pv = 32'h0000_0000;
				if (ph > 2) pv = 32'($signed(pv) >>> $urandom_range(0, 16));
				set_pos(r, pv);
			end
			if (ph == 5) quiet = 1;
			for (int i = 0; i < 235; i++) begin
				if (i % 6 == 0) begin
					cmd_q.push_back(mk(CMD_ORTHO, 0, 0, 0, 0, 0, 0));
				end else begin
					cmd_q.push_back(rnd_cmd());
				end
			end
			drain();
		end

		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/cbro_pkg.sv
rtl/core/cbro_mac.sv
rtl/core/camera_basis_rotate_orthonormalize.sv
rtl/core/cbro_chk.sv
bench/tb_top.sv
